// File: hdl/sorted_priority_queue_unit_macros.svh
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Concurrent check on clk, disabled while reset is asserted.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on clk that also holds during reset.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/spq_pkg.sv
package spq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED   = 2'd0,
    ST_POPPED     = 2'd1,
    ST_POP_EMPTY  = 2'd2,
    ST_INSERT_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] entry_id;
    logic [23:0] start_time;
    logic [23:0] end_time;
    logic [15:0] fuel;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_entry_id;
    logic [23:0] out_start_time;
    logic [23:0] out_end_time;
    logic [15:0] out_fuel;
    logic [5:0]  occupancy;
  } res_t;

  typedef struct packed {
    logic [15:0] entry_id;
    logic [23:0] start_time;
    logic [23:0] end_time;
    logic [15:0] fuel;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    logic   tie;
    entry_t ent;
  } cell_cmd_t;

endpackage

// File: hdl/spq_cell.sv
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occ,
  input  logic      tail,
  input  logic      found_in,
  input  entry_t    left,
  input  entry_t    right,
  output logic      found_out,
  output entry_t    q
);

  entry_t q_r;
  entry_t q_nxt;
  logic   ahead;
  logic   hit;

  // The new entry lands in the first cell that it goes ahead of, or at the tail.
  always_comb begin
    ahead = (cmd.ent.start_time < q_r.start_time) ||
            (cmd.tie && (cmd.ent.start_time == q_r.start_time) &&
             (cmd.ent.fuel < q_r.fuel));
    hit = cmd.ins && ((occ && ahead) || tail);
    found_out = found_in | hit;
    q_nxt = q_r;
    if (cmd.ins) begin
      if (found_in) begin
        q_nxt = left;
      end else if (hit) begin
        q_nxt = cmd.ent;
      end
    end else if (cmd.pop) begin
      q_nxt = right;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// File: hdl/sorted_priority_queue_unit.sv
// Channel   Ports                      Handshake
// request   in_req                     accepted when start is high and busy is low
// result    out_res                    shown for one cycle while out_valid is high
// config    cfg_wdata                  written when cfg_we is high
//
// A request's result appears in the cycle after it is taken.
// The row of cells compares all slots against the new entry and shifts them in the same cycle.
// busy is never raised, so a request may be given in every cycle.
// Reset empties the queue and clears the fuel tie-break setting tie_r; slot contents are not cleared.
// The result side cannot stall and needs no holding.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output res_t out_res,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          tie_r;
  logic          out_valid_r;
  res_t          res_r;
  res_t          res_nxt;
  cell_cmd_t     cmd;
  entry_t        cell_q [DEPTH];
  logic          found [DEPTH+1];
  logic          is_full;
  logic          is_empty;

  assign busy     = 1'b0;
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);

  always_comb begin
    cmd.tie = tie_r;
    cmd.ent.entry_id   = in_req.entry_id;
    cmd.ent.start_time = in_req.start_time;
    cmd.ent.end_time   = in_req.end_time;
    cmd.ent.fuel       = in_req.fuel;
    cmd.ins = start && (in_req.operation == OP_INSERT) && !is_full;
    cmd.pop = start && (in_req.operation == OP_POP) && !is_empty;
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left;
    entry_t right;
    if (i == 0) begin : g_head
      assign left = cmd.ent;
    end else begin : g_mid
      assign left = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_q[i+1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (count_r > CW'(i)),
      .tail      (count_r == CW'(i)),
      .found_in  (found[i]),
      .left      (left),
      .right     (right),
      .found_out (found[i+1]),
      .q         (cell_q[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
    res_nxt = '0;
    if (in_req.operation == OP_INSERT) begin
      res_nxt.status = is_full ? ST_INSERT_FULL : ST_INSERTED;
    end else if (is_empty) begin
      res_nxt.status = ST_POP_EMPTY;
    end else begin
      res_nxt.status         = ST_POPPED;
      res_nxt.out_entry_id   = cell_q[0].entry_id;
      res_nxt.out_start_time = cell_q[0].start_time;
      res_nxt.out_end_time   = cell_q[0].end_time;
      res_nxt.out_fuel       = cell_q[0].fuel;
    end
    res_nxt.occupancy = 6'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      tie_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= start;
      if (cfg_we) begin
        tie_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// File: hdl/spq_checker.sv
`include "sorted_priority_queue_unit_macros.svh"

module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input req_t in_req,
  input logic out_valid,
  input res_t out_res,
  input logic cfg_we,
  input logic cfg_wdata
);

  `SPQ_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
  `SPQ_ASSERT(a_result_follows, start |=> out_valid, "request without result")
  `SPQ_ASSERT(a_no_stray_result, !start |=> !out_valid, "result without request")
  `SPQ_ASSERT(a_full_occupancy, (out_valid && out_res.status == ST_INSERT_FULL) |-> (out_res.occupancy == 6'(DEPTH)), "refused insert while not full")
  `SPQ_ASSERT(a_empty_pop, (out_valid && out_res.status == ST_POP_EMPTY) |-> (out_res.occupancy == 6'd0 && out_res.out_entry_id == 16'd0), "empty pop with stored entries")

endmodule

bind sorted_priority_queue_unit spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
